[rtl/core/cdd_pkg.sv]
package cdd_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int WDAY_W  = 6;
    localparam int COUNT_W = 16;

    localparam logic [COUNT_W-1:0] LIMIT_RESET = 16'hFFFF;
    localparam logic [YEAR_W-1:0]  YEAR_MAX    = 14'h3FFF;
    localparam logic [MONTH_W:0]   MONTHS      = 5'd12;
    localparam logic [MONTH_W-1:0] FEBRUARY    = 4'd2;

    // Year / 100 is taken as (year * RECIP_100) >> RECIP_SHIFT, exact for all 14-bit years.
    localparam int RECIP_W     = 13;
    localparam int PROD_W      = YEAR_W + RECIP_W;
    localparam int RECIP_SHIFT = 19;
    localparam int QUOT_W      = PROD_W - RECIP_SHIFT;
    localparam int MOD100_W    = 7;
    localparam logic [RECIP_W-1:0]  RECIP_100    = 13'd5243;
    localparam logic [MOD100_W-1:0] CENTURY      = 7'd100;
    localparam logic [MOD100_W-1:0] CENTURY_LAST = 7'd99;

    localparam logic [DAY_W-1:0] MONTH_LEN [16] = '{
        5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
        5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
    };

    typedef struct packed {
        logic [YEAR_W-1:0]  start_year;
        logic [MONTH_W-1:0] start_month;
        logic [DAY_W-1:0]   start_day;
        logic [YEAR_W-1:0]  end_year;
        logic [MONTH_W-1:0] end_month;
        logic [DAY_W-1:0]   end_day;
    } t_in_beat;

    typedef struct packed {
        logic [COUNT_W-1:0] day_count;
        logic               timed_out;
    } t_out_beat;

    typedef struct packed {
        logic load;
        logic divide;
        logic remainder;
        logic step;
        logic report;
        logic timed_out;
    } t_cmd;

    typedef struct packed {
        logic limit_reached;
        logic date_match;
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_REMAINDER,
        ST_WALK
    } t_state;

endpackage

[rtl/core/cdd_ctrl.sv]
module cdd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  cdd_pkg::t_status i_status,
    output cdd_pkg::t_cmd    o_cmd,
    output logic             o_idle
);

    cdd_pkg::t_state r_state;
    cdd_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cdd_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            cdd_pkg::ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = cdd_pkg::ST_DIVIDE;
                end
            end
            cdd_pkg::ST_DIVIDE: begin
                o_cmd.divide = 1'b1;
                n_state      = cdd_pkg::ST_REMAINDER;
            end
            cdd_pkg::ST_REMAINDER: begin
                o_cmd.remainder = 1'b1;
                n_state         = cdd_pkg::ST_WALK;
            end
            cdd_pkg::ST_WALK: begin
                if (i_status.limit_reached) begin
                    o_cmd.report    = 1'b1;
                    o_cmd.timed_out = 1'b1;
                    n_state         = cdd_pkg::ST_IDLE;
                end else begin
                    o_cmd.step = 1'b1;
                    if (i_status.date_match) begin
                        o_cmd.report = 1'b1;
                        n_state      = cdd_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = cdd_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_idle = (r_state == cdd_pkg::ST_IDLE);

endmodule

[rtl/core/cdd_datapath.sv]
module cdd_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  cdd_pkg::t_in_beat            i_dates,
    input  logic                         i_cfg_we,
    input  logic [cdd_pkg::COUNT_W-1:0]  i_cfg_data,
    input  cdd_pkg::t_cmd                i_cmd,
    output cdd_pkg::t_status             o_status,
    output logic                         o_done,
    output cdd_pkg::t_out_beat           o_result
);

    localparam int YW = cdd_pkg::YEAR_W;
    localparam int MW = cdd_pkg::MONTH_W;
    localparam int DW = cdd_pkg::DAY_W;
    localparam int WW = cdd_pkg::WDAY_W;
    localparam int CW = cdd_pkg::COUNT_W;
    localparam int RW = cdd_pkg::MOD100_W;

    logic [CW-1:0]                r_limit;
    logic [YW-1:0]                r_year;
    logic [MW-1:0]                r_month;
    logic [WW-1:0]                r_day;
    logic [CW-1:0]                r_count;
    logic [YW-1:0]                r_end_year;
    logic [MW-1:0]                r_end_month;
    logic [DW-1:0]                r_end_day;
    logic [cdd_pkg::PROD_W-1:0]   r_prod;
    logic [RW-1:0]                r_mod100;
    logic [1:0]                   r_cent_mod4;
    logic                         r_done;
    cdd_pkg::t_out_beat           r_result;

    logic                         leap;
    logic [DW:0]                  len;
    logic [WW:0]                  day_inc;
    logic                         roll;
    logic [WW:0]                  day_sum;
    logic [MW:0]                  month_sum;
    logic                         year_wrap;
    logic [YW-1:0]                n_year;
    logic [MW-1:0]                n_month;
    logic [WW-1:0]                n_day;
    logic [RW-1:0]                n_mod100;
    logic [1:0]                   n_cent_mod4;
    logic [CW-1:0]                count_inc;
    logic [cdd_pkg::QUOT_W-1:0]   quot;
    logic [YW-1:0]                quot_x100;
    logic [YW-1:0]                rem_full;

    always_comb begin
        leap = ((r_year[1:0] == 2'b00) && (r_mod100 != '0))
            || ((r_mod100 == '0) && (r_cent_mod4 == 2'b00));
        len = {1'b0, cdd_pkg::MONTH_LEN[r_month]};
        if ((r_month == cdd_pkg::FEBRUARY) && leap) begin
            len = len + 1'b1;
        end
        day_inc   = {1'b0, r_day} + 1'b1;
        roll      = day_inc > {{(WW-DW){1'b0}}, len};
        day_sum   = roll ? (day_inc - {{(WW-DW){1'b0}}, len}) : day_inc;
        month_sum = {1'b0, r_month} + {{MW{1'b0}}, roll};
        year_wrap = month_sum > cdd_pkg::MONTHS;
        if (year_wrap) begin
            month_sum = month_sum - cdd_pkg::MONTHS;
        end
        n_day   = day_sum[WW-1:0];
        n_month = month_sum[MW-1:0];
        n_year      = r_year;
        n_mod100    = r_mod100;
        n_cent_mod4 = r_cent_mod4;
        if (year_wrap) begin
            n_year = r_year + 1'b1;
            if (r_year == cdd_pkg::YEAR_MAX) begin
                n_mod100    = '0;
                n_cent_mod4 = '0;
            end else if (r_mod100 == cdd_pkg::CENTURY_LAST) begin
                n_mod100    = '0;
                n_cent_mod4 = r_cent_mod4 + 1'b1;
            end else begin
                n_mod100 = r_mod100 + 1'b1;
            end
        end
        count_inc = r_count + 1'b1;
        quot      = r_prod[cdd_pkg::PROD_W-1:cdd_pkg::RECIP_SHIFT];
        quot_x100 = ({{(YW-cdd_pkg::QUOT_W){1'b0}}, quot} << 6)
                  + ({{(YW-cdd_pkg::QUOT_W){1'b0}}, quot} << 5)
                  + ({{(YW-cdd_pkg::QUOT_W){1'b0}}, quot} << 2);
        rem_full  = r_year - quot_x100;
    end

    assign o_status.limit_reached = (r_count == r_limit);
    assign o_status.date_match    = (n_year == r_end_year) && (n_month == r_end_month)
                                 && (n_day == {1'b0, r_end_day});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= cdd_pkg::LIMIT_RESET;
            r_done  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            r_done <= i_cmd.report;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_year      <= i_dates.start_year;
            r_month     <= i_dates.start_month;
            r_day       <= {1'b0, i_dates.start_day};
            r_count     <= '0;
            r_end_year  <= i_dates.end_year;
            r_end_month <= i_dates.end_month;
            r_end_day   <= i_dates.end_day;
        end
        if (i_cmd.divide) begin
            r_prod <= {{cdd_pkg::RECIP_W{1'b0}}, r_year}
                    * {{YW{1'b0}}, cdd_pkg::RECIP_100};
        end
        if (i_cmd.remainder) begin
            r_mod100    <= rem_full[RW-1:0];
            r_cent_mod4 <= quot[1:0];
        end
        if (i_cmd.step) begin
            r_year      <= n_year;
            r_month     <= n_month;
            r_day       <= n_day;
            r_count     <= count_inc;
            r_mod100    <= n_mod100;
            r_cent_mod4 <= n_cent_mod4;
        end
        if (i_cmd.report) begin
            r_result.day_count <= i_cmd.timed_out ? r_count : count_inc;
            r_result.timed_out <= i_cmd.timed_out;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

[rtl/core/calendar_day_difference_top.sv]
// On start the controller loads the dates, divides the start year by 100, takes the remainder and
// then walks one day per step until the end date matches or the step count reaches the day limit.
// A new date pair is accepted only in idle, after the result of the previous one is reported.
// The result is held on o_result for the single cycle o_done is high and cannot be stalled.
// Synchronous active-low reset returns the controller to idle and sets the limit to 65535.
module calendar_day_difference_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  cdd_pkg::t_in_beat           i_dates,
    output logic                        o_done,
    output cdd_pkg::t_out_beat          o_result,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [cdd_pkg::COUNT_W-1:0] i_cfg_data
);

    cdd_pkg::t_cmd    cmd;
    cdd_pkg::t_status status;
    logic             idle;

    cdd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_cmd    (cmd),
        .o_idle   (idle)
    );

    cdd_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_dates    (i_dates),
        .i_cfg_we   (i_cfg_valid && idle),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_done     (o_done),
        .o_result   (o_result)
    );

    assign busy        = !idle;
    assign o_cfg_ready = idle;

endmodule

[sim/calendar_day_difference_top_tb.sv]
`timescale 1ns / 1ps

module calendar_day_difference_top_tb;

    localparam int CYCLE_LIMIT   = 4_000_000;
    localparam int SETTLE_CYCLES = 16;
    localparam int CALM_FROM     = 80;
    localparam bit TYPED         = 1'b1;
    localparam bit PREDICTED     = 1'b0;

    typedef struct packed {
        logic [cdd_pkg::YEAR_W-1:0]  y;
        logic [cdd_pkg::MONTH_W-1:0] m;
        logic [cdd_pkg::WDAY_W-1:0]  d;
    } t_walk_date;

    typedef struct packed {
        logic [cdd_pkg::COUNT_W-1:0] limit;
        cdd_pkg::t_in_beat           dates;
        logic                        typed;
        cdd_pkg::t_out_beat          want;
    } t_case;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        start;
    logic                        busy;
    cdd_pkg::t_in_beat           i_dates;
    logic                        o_done;
    cdd_pkg::t_out_beat          o_result;
    logic                        i_cfg_valid;
    logic                        o_cfg_ready;
    logic [cdd_pkg::COUNT_W-1:0] i_cfg_data;

    cdd_pkg::t_out_beat          day_counts_due[$];
    t_case                       directed_cases[$];
    cdd_pkg::t_out_beat          oldest;
    logic [cdd_pkg::COUNT_W-1:0] day_limit_now;
    int                          errors     = 0;
    int                          items_sent = 0;

    calendar_day_difference_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_dates     (i_dates),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    function automatic bit leap_year(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned month_length(input int unsigned y, input int unsigned m);
        int unsigned len;
        len = 32'(cdd_pkg::MONTH_LEN[m[cdd_pkg::MONTH_W-1:0]]);
        if (m[cdd_pkg::MONTH_W-1:0] == cdd_pkg::FEBRUARY && leap_year(y)) begin
            len++;
        end
        return len;
    endfunction

    function automatic t_walk_date next_date(input t_walk_date w);
        int unsigned d;
        int unsigned m;
        int unsigned y;
        int unsigned len;
        t_walk_date  n;
        d = 32'(w.d);
        m = 32'(w.m);
        y = 32'(w.y);
        d = d + 1;
        len = month_length(y, m);
        if (d > len) begin
            d = d - len;
            m = m + 1;
        end
        if (m > 12) begin
            m = m - 12;
            y = (y + 1) % (1 << cdd_pkg::YEAR_W);
        end
        n.y = y[cdd_pkg::YEAR_W-1:0];
        n.m = m[cdd_pkg::MONTH_W-1:0];
        n.d = d[cdd_pkg::WDAY_W-1:0];
        return n;
    endfunction

    function automatic cdd_pkg::t_out_beat walk_day_count(input cdd_pkg::t_in_beat dates,
                                                          input logic [cdd_pkg::COUNT_W-1:0] limit);
        t_walk_date         w;
        int unsigned        steps;
        logic               hit;
        cdd_pkg::t_out_beat r;
        w.y = dates.start_year;
        w.m = dates.start_month;
        w.d = {1'b0, dates.start_day};
        steps = 0;
        hit = 1'b0;
        while (!hit && steps < 32'(limit)) begin
            w = next_date(w);
            steps++;
            hit = (w.y == dates.end_year) && (w.m == dates.end_month) &&
                  (w.d == {1'b0, dates.end_day});
        end
        r.day_count = steps[cdd_pkg::COUNT_W-1:0];
        r.timed_out = !hit;
        return r;
    endfunction

    function automatic cdd_pkg::t_in_beat date_after(input cdd_pkg::t_in_beat dates,
                                                     input int unsigned n);
        t_walk_date        w;
        cdd_pkg::t_in_beat r;
        w.y = dates.start_year;
        w.m = dates.start_month;
        w.d = {1'b0, dates.start_day};
        repeat (n) w = next_date(w);
        r = dates;
        r.end_year = w.y;
        r.end_month = w.m;
        r.end_day = w.d[cdd_pkg::DAY_W-1:0];
        return r;
    endfunction

    function automatic t_case mk_case(input logic [cdd_pkg::COUNT_W-1:0] limit,
                                      input int unsigned sy, input int unsigned sm,
                                      input int unsigned sd, input int unsigned ey,
                                      input int unsigned em, input int unsigned ed,
                                      input bit typed, input int unsigned cnt, input bit to);
        t_case c;
        c.limit = limit;
        c.dates.start_year = sy[cdd_pkg::YEAR_W-1:0];
        c.dates.start_month = sm[cdd_pkg::MONTH_W-1:0];
        c.dates.start_day = sd[cdd_pkg::DAY_W-1:0];
        c.dates.end_year = ey[cdd_pkg::YEAR_W-1:0];
        c.dates.end_month = em[cdd_pkg::MONTH_W-1:0];
        c.dates.end_day = ed[cdd_pkg::DAY_W-1:0];
        c.typed = typed;
        c.want.day_count = cnt[cdd_pkg::COUNT_W-1:0];
        c.want.timed_out = to;
        return c;
    endfunction

    task automatic pause_sender(input int n);
        @(negedge i_clk);
        start <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    task automatic send_dates(input cdd_pkg::t_in_beat dates, input cdd_pkg::t_out_beat want);
        @(negedge i_clk);
        start <= 1'b1;
        i_dates <= dates;
        do @(posedge i_clk); while (busy);
        day_counts_due.push_back(want);
        items_sent++;
        if (items_sent < CALM_FROM && $urandom_range(0, 2) == 0) begin
            pause_sender($urandom_range(1, 19));
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (day_counts_due.size() != 0 || busy) @(posedge i_clk);
    endtask

    task automatic set_day_limit(input logic [cdd_pkg::COUNT_W-1:0] value);
        wait_drained();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        day_limit_now = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("TEST FAILED");
        $finish;
    end

    // Every result beat is matched against the oldest outstanding expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (day_counts_due.size() == 0) begin
                $error("unexpected result: day_count %0d timed_out %0b",
                       o_result.day_count, o_result.timed_out);
                errors++;
            end else begin
                oldest = day_counts_due.pop_front();
                if (o_result.day_count !== oldest.day_count) begin
                    $error("day_count: expected %0d, actual %0d",
                           oldest.day_count, o_result.day_count);
                    errors++;
                end
                if (o_result.timed_out !== oldest.timed_out) begin
                    $error("timed_out: expected %0b, actual %0b",
                           oldest.timed_out, o_result.timed_out);
                    errors++;
                end
            end
        end
    end

    initial begin
        cdd_pkg::t_in_beat  dates;
        cdd_pkg::t_out_beat want;
        int unsigned        lim;
        int unsigned        span;
        int unsigned        count;
        int unsigned        steps;
        int unsigned        sel;

        i_rst_n = 1'b0;
        start = 1'b0;
        i_dates = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        day_limit_now = cdd_pkg::LIMIT_RESET;

        directed_cases.push_back(mk_case(16'hFFFF, 2024, 1, 1, 2024, 1, 2, TYPED, 1, 0));
        directed_cases.push_back(mk_case(16'hFFFF, 9999, 12, 31, 9999, 12, 31,
                                         TYPED, 65535, 1));
        directed_cases.push_back(mk_case(16'hFFFF, 2000, 2, 28, 2000, 3, 1, PREDICTED, 0, 0));
        directed_cases.push_back(mk_case(16'hFFFF, 1900, 2, 28, 1900, 3, 1, PREDICTED, 0, 0));
        directed_cases.push_back(mk_case(16'hFFFF, 2023, 2, 28, 2023, 3, 1, PREDICTED, 0, 0));
        directed_cases.push_back(mk_case(16'hFFFF, 16383, 12, 31, 0, 1, 1, TYPED, 1, 0));
        directed_cases.push_back(mk_case(16'hFFFF, 0, 1, 1, 1, 1, 1, PREDICTED, 0, 0));
        directed_cases.push_back(mk_case(16'hFFFF, 2023, 4, 31, 2023, 5, 2, PREDICTED, 0, 0));
        directed_cases.push_back(mk_case(16'hFFFF, 2023, 0, 15, 2023, 1, 16, PREDICTED, 0, 0));
        directed_cases.push_back(mk_case(16'hFFFF, 2023, 13, 5, 2024, 2, 6, PREDICTED, 0, 0));
        directed_cases.push_back(mk_case(16'hFFFF, 16383, 15, 31, 0, 5, 3, PREDICTED, 0, 0));
        directed_cases.push_back(mk_case(16'hFFFF, 2023, 3, 0, 2023, 3, 1, PREDICTED, 0, 0));
        directed_cases.push_back(mk_case(16'd1, 2000, 3, 1, 2000, 2, 29, TYPED, 1, 1));
        directed_cases.push_back(mk_case(16'd1, 2000, 2, 28, 2000, 2, 29, TYPED, 1, 0));
        directed_cases.push_back(mk_case(16'd0, 2024, 1, 1, 2024, 1, 2, TYPED, 0, 1));
        directed_cases.push_back(mk_case(16'd0, 0, 0, 0, 0, 0, 0, TYPED, 0, 1));
        directed_cases.push_back(mk_case(16'd59, 2024, 1, 1, 2024, 2, 29, PREDICTED, 0, 0));
        directed_cases.push_back(mk_case(16'd59, 2023, 1, 1, 2023, 3, 1, PREDICTED, 0, 0));
        directed_cases.push_back(mk_case(16'd58, 2023, 1, 1, 2023, 3, 1, PREDICTED, 0, 0));
        directed_cases.push_back(mk_case(16'd400, 2023, 4, 1, 2023, 4, 31, PREDICTED, 0, 0));
        directed_cases.push_back(mk_case(16'd400, 2023, 1, 1, 2023, 13, 1, PREDICTED, 0, 0));
        directed_cases.push_back(mk_case(16'hFFFF, 2024, 12, 31, 2025, 1, 1, PREDICTED, 0, 0));

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_cases[i]) begin
            if (directed_cases[i].limit != day_limit_now) begin
                set_day_limit(directed_cases[i].limit);
            end
            want = directed_cases[i].typed ? directed_cases[i].want :
                   walk_day_count(directed_cases[i].dates, day_limit_now);
            send_dates(directed_cases[i].dates, want);
        end

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin lim = 2;     count = 12; end
                1: begin lim = 31;    count = 11; end
                2: begin lim = 366;   count = 11; end
                3: begin lim = 1461;  count = 11; end
                4: begin lim = 4096;  count = 11; end
                5: begin lim = $urandom_range(3, 4096); count = 11; end
                6: begin lim = 20000; count = 4;  end
                default: begin lim = 65535; count = 11; end
            endcase
            set_day_limit(lim[cdd_pkg::COUNT_W-1:0]);
            span = (lim > 20000) ? 1500 : lim;
            for (int n = 0; n < count; n++) begin
                if (phase == 3 && n == 7) begin
                    wait_drained();
                end
                sel = $urandom_range(0, 19);
                dates = '0;
                if (lim <= 4096 && sel < 3) begin
                    dates.start_year = 14'($urandom_range(0, cdd_pkg::YEAR_MAX));
                    dates.start_month = 4'($urandom_range(0, 15));
                    dates.start_day = 5'($urandom_range(0, 31));
                    if (sel == 0) begin
                        dates.end_year = dates.start_year;
                        dates.end_month = dates.start_month;
                        dates.end_day = dates.start_day;
                    end else begin
                        dates.end_year = 14'($urandom_range(0, cdd_pkg::YEAR_MAX));
                        dates.end_month = 4'($urandom_range(0, 15));
                        dates.end_day = 5'($urandom_range(0, 31));
                    end
                end else begin
                    if ($urandom_range(0, 9) == 0) begin
                        dates.start_year = 14'($urandom_range(0, cdd_pkg::YEAR_MAX));
                    end else begin
                        dates.start_year = 14'($urandom_range(0, 9999));
                    end
                    dates.start_month = 4'($urandom_range(1, 12));
                    dates.start_day = 5'($urandom_range(1,
                                          month_length(32'(dates.start_year),
                                                       32'(dates.start_month))));
                    if (sel == 3) begin
                        steps = span;
                    end else if (sel == 4 && lim <= 4096) begin
                        steps = lim + 1;
                    end else begin
                        steps = $urandom_range(1, span);
                    end
                    dates = date_after(dates, steps);
                end
                send_dates(dates, walk_day_count(dates, day_limit_now));
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
